// ===== rtl/bco_pkg.sv =====
// ----------------------------------------------------------------------------
// bco_pkg: shared types and constants of the blob centroid offset block
// Field widths, register map, reset values and the command and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package bco_pkg;

   // Item field widths.
   localparam int PIXEL_W     = 8;
   localparam int SIZE_REG_W  = 11;
   localparam int THR_W       = 8;
   localparam int TALLY_W     = 21;
   localparam int TROW_W      = 10;
   localparam int ERR_W       = 16;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_PAD_W   = RSP_DATA_W - TALLY_W - 2 * ERR_W;

   // Configuration port.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int REG_IDX_W   = 3;

   // Defaults for the top-level parameters.
   localparam int MAX_WIDTH_DEF       = 1024;
   localparam int MAX_HEIGHT_DEF      = 1024;
   localparam int ERROR_FRAC_BITS_DEF = 13;

   // Register indexes (byte address is four times the index).
   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MIN_PIXELS   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TARGET_ROW   = 3'd4;

   // Register reset values.
   localparam logic [SIZE_REG_W-1:0] FRAME_WIDTH_RST  = 11'd160;
   localparam logic [SIZE_REG_W-1:0] FRAME_HEIGHT_RST = 11'd120;
   localparam logic [THR_W-1:0]      THRESHOLD_RST    = 8'd128;
   localparam logic [TALLY_W-1:0]    MIN_PIXELS_RST   = 21'd50;
   localparam logic [TROW_W-1:0]     TARGET_ROW_RST   = 10'd100;

   // Saturation limits of the signed error outputs.
   localparam logic [ERR_W-1:0] ERR_POS_LIMIT = 16'h7fff;
   localparam logic [ERR_W-1:0] ERR_NEG_LIMIT = 16'h8000;

   typedef struct packed {
      logic [SIZE_REG_W-1:0] frame_width;
      logic [SIZE_REG_W-1:0] frame_height;
      logic [THR_W-1:0]      object_threshold;
      logic [TALLY_W-1:0]    min_object_pixels;
      logic [TROW_W-1:0]     target_row;
   } cfg_type;

   typedef enum logic [1:0] {
      MSEL_WIDTH  = 2'd0,
      MSEL_TROW   = 2'd1,
      MSEL_HEIGHT = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        accept;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        prep_h;
      logic        prep_v;
      logic        div_step;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
      logic found;
      logic div_last;
   } status_type;

endpackage

// ===== rtl/blob_centroid_offset.sv =====
// ----------------------------------------------------------------------------
// blob_centroid_offset: centroid offset of dark pixels in a mask stream
// Streams 8-bit mask pixels in raster order and reports, once per frame,
// whether an object was seen and its normalized centroid offsets.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one pixel per item in raster order; the block keeps
// its own column and row from the frame size registers. Pixels below the
// threshold count as object pixels. The rsp channel carries one item per
// frame: found in tuser, errors and object count in tdata.
// Inside a frame a pixel is taken every cycle. After the last pixel of a
// frame, req_tready stays low while the shared multiplier forms three
// products and a restoring divider produces one quotient bit a cycle for
// each error (with no object found, only the width product is formed),
// and until the result register is loaded; the result becomes valid as
// req_tready rises again. The result register holds a finished item, so
// the next frame streams in while the receiver stalls; only the following
// frame end waits for the register to empty. Reset clears the position
// counters, sums and tally and restores the register defaults.
// ----------------------------------------------------------------------------
module blob_centroid_offset #(
   parameter int MAX_WIDTH       = bco_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT      = bco_pkg::MAX_HEIGHT_DEF,
   parameter int ERROR_FRAC_BITS = bco_pkg::ERROR_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Pixel input.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bco_pkg::PIXEL_W-1:0]        req_tdata,   // [7:0] pixel
   // Result output.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] horiz_error, [31:16] vert_error, [52:32] object_count, [55:53] zero
   output logic [bco_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser,   // [0] found
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bco_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bco_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bco_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   bco_pkg::cfg_type            cfg;
   bco_pkg::cmd_type            cmd;
   bco_pkg::status_type         status;
   logic                        rsp_found;
   logic [bco_pkg::ERR_W-1:0]   rsp_horiz, rsp_vert;
   logic [bco_pkg::TALLY_W-1:0] rsp_count;

   bco_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bco_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   bco_dp #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .ERROR_FRAC_BITS (ERROR_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .pixel     (req_tdata),
      .status    (status),
      .rsp_found (rsp_found),
      .rsp_horiz (rsp_horiz),
      .rsp_vert  (rsp_vert),
      .rsp_count (rsp_count)
   );

   assign rsp_tdata = {{bco_pkg::RSP_PAD_W{1'b0}}, rsp_count, rsp_vert, rsp_horiz};
   assign rsp_tuser = rsp_found;

   // A frame-ending pixel must stop the input while the result is formed.
   a_stall_after_frame_end: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && status.frame_end |=> !req_tready)
      else $error("input not stalled after frame end");

   // The result register is only loaded when its item is gone or leaving.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_tvalid || rsp_tready)
      else $error("result overwritten before it was taken");

   // A frame without an object reports zero errors.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero error without an object");

   // An object can only be found with a nonzero pixel count.
   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[52:32] != 21'd0)
      else $error("object found with zero count");

endmodule

// ===== rtl/bco_csr.sv =====
// ----------------------------------------------------------------------------
// bco_csr: configuration registers
// Holds the five frame and detection settings behind a simple bus port.
// ----------------------------------------------------------------------------
module bco_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bco_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bco_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bco_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output bco_pkg::cfg_type                  cfg
);

   logic [bco_pkg::SIZE_REG_W-1:0] frame_width_ff, frame_width_in;
   logic [bco_pkg::SIZE_REG_W-1:0] frame_height_ff, frame_height_in;
   logic [bco_pkg::THR_W-1:0]      threshold_ff, threshold_in;
   logic [bco_pkg::TALLY_W-1:0]    min_pixels_ff, min_pixels_in;
   logic [bco_pkg::TROW_W-1:0]     target_row_ff, target_row_in;
   logic [bco_pkg::REG_IDX_W-1:0]  reg_idx;
   logic                           wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[bco_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      threshold_in    = threshold_ff;
      min_pixels_in   = min_pixels_ff;
      target_row_in   = target_row_ff;
      if (wr_en) begin
         case (reg_idx)
            bco_pkg::REG_FRAME_WIDTH:
               frame_width_in = csr_pwdata[bco_pkg::SIZE_REG_W-1:0];
            bco_pkg::REG_FRAME_HEIGHT:
               frame_height_in = csr_pwdata[bco_pkg::SIZE_REG_W-1:0];
            bco_pkg::REG_THRESHOLD:
               threshold_in = csr_pwdata[bco_pkg::THR_W-1:0];
            bco_pkg::REG_MIN_PIXELS:
               min_pixels_in = csr_pwdata[bco_pkg::TALLY_W-1:0];
            bco_pkg::REG_TARGET_ROW:
               target_row_in = csr_pwdata[bco_pkg::TROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         bco_pkg::REG_FRAME_WIDTH:  csr_prdata = bco_pkg::CSR_DATA_W'(frame_width_ff);
         bco_pkg::REG_FRAME_HEIGHT: csr_prdata = bco_pkg::CSR_DATA_W'(frame_height_ff);
         bco_pkg::REG_THRESHOLD:    csr_prdata = bco_pkg::CSR_DATA_W'(threshold_ff);
         bco_pkg::REG_MIN_PIXELS:   csr_prdata = bco_pkg::CSR_DATA_W'(min_pixels_ff);
         bco_pkg::REG_TARGET_ROW:   csr_prdata = bco_pkg::CSR_DATA_W'(target_row_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bco_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= bco_pkg::FRAME_HEIGHT_RST;
         threshold_ff    <= bco_pkg::THRESHOLD_RST;
         min_pixels_ff   <= bco_pkg::MIN_PIXELS_RST;
         target_row_ff   <= bco_pkg::TARGET_ROW_RST;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         threshold_ff    <= threshold_in;
         min_pixels_ff   <= min_pixels_in;
         target_row_ff   <= target_row_in;
      end
   end

   assign cfg.frame_width       = frame_width_ff;
   assign cfg.frame_height      = frame_height_ff;
   assign cfg.object_threshold  = threshold_ff;
   assign cfg.min_object_pixels = min_pixels_ff;
   assign cfg.target_row        = target_row_ff;

endmodule

// ===== rtl/bco_ctrl.sv =====
// ----------------------------------------------------------------------------
// bco_ctrl: frame sequencer
// Accepts pixels, and at the end of a frame steps the datapath through the
// products, the two divisions a found object needs and the result load.
// ----------------------------------------------------------------------------
module bco_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   input  bco_pkg::status_type  status,
   output bco_pkg::cmd_type     cmd
);

   typedef enum logic [8:0] {
      ST_RUN    = 9'b000000001,
      ST_MUL_W  = 9'b000000010,
      ST_MUL_T  = 9'b000000100,
      ST_MUL_H  = 9'b000001000,
      ST_PREP_H = 9'b000010000,
      ST_DIV_H  = 9'b000100000,
      ST_PREP_V = 9'b001000000,
      ST_DIV_V  = 9'b010000000,
      ST_LOAD   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_RUN);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = bco_pkg::MSEL_WIDTH;
      case (state_ff)
         ST_RUN: begin
            cmd.accept = req_tvalid;
            if (req_tvalid && status.frame_end) begin
               state_in = ST_MUL_W;
            end
         end
         ST_MUL_W: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bco_pkg::MSEL_WIDTH;
            // An empty or too small object skips the divisions.
            state_in = status.found ? ST_MUL_T : ST_LOAD;
         end
         ST_MUL_T: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bco_pkg::MSEL_TROW;
            state_in    = ST_MUL_H;
         end
         ST_MUL_H: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bco_pkg::MSEL_HEIGHT;
            state_in    = ST_PREP_H;
         end
         ST_PREP_H: begin
            cmd.prep_h = 1'b1;
            state_in   = ST_DIV_H;
         end
         ST_DIV_H: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PREP_V;
            end
         end
         ST_PREP_V: begin
            cmd.prep_v = 1'b1;
            state_in   = ST_DIV_V;
         end
         ST_DIV_V: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/bco_dp.sv =====
// ----------------------------------------------------------------------------
// bco_dp: centroid datapath
// Position counters, column and row sums, object tally, a shared multiplier,
// a restoring divider that yields one quotient bit per cycle, and the result
// register.
// ----------------------------------------------------------------------------
module bco_dp #(
   parameter int MAX_WIDTH       = bco_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT      = bco_pkg::MAX_HEIGHT_DEF,
   parameter int ERROR_FRAC_BITS = bco_pkg::ERROR_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bco_pkg::cfg_type              cfg,
   input  bco_pkg::cmd_type              cmd,
   input  logic [bco_pkg::PIXEL_W-1:0]   pixel,
   output bco_pkg::status_type           status,
   output logic                          rsp_found,
   output logic [bco_pkg::ERR_W-1:0]     rsp_horiz,
   output logic [bco_pkg::ERR_W-1:0]     rsp_vert,
   output logic [bco_pkg::TALLY_W-1:0]   rsp_count
);

   localparam int CNT_C_W  = $clog2(MAX_WIDTH);
   localparam int CNT_R_W  = $clog2(MAX_HEIGHT);
   localparam int SIZE_C_W = $clog2(MAX_WIDTH + 1);
   localparam int SIZE_R_W = $clog2(MAX_HEIGHT + 1);
   localparam int SUM_C_W  = CNT_C_W + bco_pkg::TALLY_W;
   localparam int SUM_R_W  = CNT_R_W + bco_pkg::TALLY_W;
   localparam int MA_W0    = (SIZE_C_W > SIZE_R_W) ? SIZE_C_W : SIZE_R_W;
   localparam int MA_W     = (MA_W0 > bco_pkg::TROW_W) ? MA_W0 : bco_pkg::TROW_W;
   localparam int PW       = MA_W + bco_pkg::TALLY_W;
   localparam int DW0      = (SUM_C_W > SUM_R_W) ? SUM_C_W + 1 : SUM_R_W + 1;
   localparam int DW       = (DW0 > PW + 1) ? DW0 : PW + 1;
   localparam int XW       = DW + ERROR_FRAC_BITS;
   localparam int STEP_W   = $clog2(XW + 1);

   // Position and accumulation state.
   logic [CNT_C_W-1:0]          col_ff, col_in;
   logic [CNT_R_W-1:0]          row_ff, row_in;
   logic [SUM_C_W-1:0]          col_sum_ff, col_sum_in;
   logic [SUM_R_W-1:0]          row_sum_ff, row_sum_in;
   logic [bco_pkg::TALLY_W-1:0] tally_ff, tally_in;
   logic [STEP_W-1:0]           step_ff, step_in;

   // Per-frame arithmetic.
   logic [PW-1:0]               prod_w_ff, prod_t_ff, prod_h_ff;
   logic [PW-1:0]               den_ff;
   logic [PW-1:0]               rem_ff;
   logic [XW-1:0]               x_ff;
   logic                        neg_ff;
   logic [bco_pkg::ERR_W-1:0]   horiz_ff;

   logic                        rsp_found_ff;
   logic [bco_pkg::ERR_W-1:0]   rsp_horiz_ff, rsp_vert_ff;
   logic [bco_pkg::TALLY_W-1:0] rsp_count_ff;

   logic [SIZE_C_W-1:0]         w_eff;
   logic [SIZE_R_W-1:0]         h_eff;
   logic [CNT_C_W-1:0]          w_last;
   logic [CNT_R_W-1:0]          h_last;
   logic                        col_end, row_end;
   logic                        is_object;
   logic                        found;
   logic [MA_W-1:0]             mul_a;
   logic [PW-1:0]               product;
   logic [DW:0]                 h_diff, v_diff, h_abs, v_abs;
   logic [PW:0]                 rem_sh;
   logic [PW+1:0]               trial;
   logic                        q_bit;
   logic [PW-1:0]               rem_step;
   logic [XW-1:0]               x_step;

   function automatic logic [bco_pkg::ERR_W-1:0] sat_err(input logic [XW-1:0] q,
                                                         input logic neg);
      logic [XW-1:0] lim;
      lim = neg ? XW'(bco_pkg::ERR_NEG_LIMIT) : XW'(bco_pkg::ERR_POS_LIMIT);
      if (q > lim) begin
         sat_err = neg ? bco_pkg::ERR_NEG_LIMIT : bco_pkg::ERR_POS_LIMIT;
      end else if (neg) begin
         sat_err = bco_pkg::ERR_W'(0) - q[bco_pkg::ERR_W-1:0];
      end else begin
         sat_err = q[bco_pkg::ERR_W-1:0];
      end
   endfunction

   // A size of zero acts as one; sizes above the maximum act as the maximum.
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_eff = SIZE_C_W'(1);
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         w_eff = SIZE_C_W'(MAX_WIDTH);
      end else begin
         w_eff = SIZE_C_W'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         h_eff = SIZE_R_W'(1);
      end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
         h_eff = SIZE_R_W'(MAX_HEIGHT);
      end else begin
         h_eff = SIZE_R_W'(cfg.frame_height);
      end
   end

   assign w_last    = CNT_C_W'(w_eff - SIZE_C_W'(1));
   assign h_last    = CNT_R_W'(h_eff - SIZE_R_W'(1));
   assign col_end   = (col_ff >= w_last);
   assign row_end   = (row_ff >= h_last);
   assign is_object = (pixel < cfg.object_threshold);
   assign found     = (tally_ff != '0) && (tally_ff >= cfg.min_object_pixels);

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      col_sum_in = col_sum_ff;
      row_sum_in = row_sum_ff;
      tally_in   = tally_ff;
      if (cmd.accept) begin
         if (is_object) begin
            col_sum_in = col_sum_ff + SUM_C_W'(col_ff);
            row_sum_in = row_sum_ff + SUM_R_W'(row_ff);
            tally_in   = tally_ff + bco_pkg::TALLY_W'(1);
         end
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + CNT_R_W'(1);
         end else begin
            col_in = col_ff + CNT_C_W'(1);
         end
      end
      if (cmd.load_out) begin
         col_sum_in = '0;
         row_sum_in = '0;
         tally_in   = '0;
      end
   end

   // Shared multiplier for width*count, target_row*count and height*count.
   always_comb begin
      case (cmd.mul_sel)
         bco_pkg::MSEL_WIDTH:  mul_a = MA_W'(w_eff);
         bco_pkg::MSEL_TROW:   mul_a = MA_W'(cfg.target_row);
         bco_pkg::MSEL_HEIGHT: mul_a = MA_W'(h_eff);
         default:              mul_a = '0;
      endcase
   end
   assign product = PW'(mul_a) * PW'(tally_ff);

   // Numerators: 2*column_sum - w*c and 2*(row_sum - target_row*c).
   assign h_diff = ((DW+1)'(col_sum_ff) << 1) - (DW+1)'(prod_w_ff);
   assign v_diff = ((DW+1)'(row_sum_ff) - (DW+1)'(prod_t_ff)) << 1;
   assign h_abs  = h_diff[DW] ? (DW+1)'(0) - h_diff : h_diff;
   assign v_abs  = v_diff[DW] ? (DW+1)'(0) - v_diff : v_diff;

   // One restoring step: the dividend shifts out of x while quotient bits
   // shift in at the bottom.
   assign rem_sh   = {rem_ff, x_ff[XW-1]};
   assign trial    = {1'b0, rem_sh} - {2'b00, den_ff};
   assign q_bit    = !trial[PW+1];
   assign rem_step = q_bit ? trial[PW-1:0] : rem_sh[PW-1:0];
   assign x_step   = {x_ff[XW-2:0], q_bit};

   always_comb begin
      step_in = step_ff;
      if (cmd.prep_h || cmd.prep_v) begin
         step_in = STEP_W'(XW);
      end else if (cmd.div_step) begin
         step_in = step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         col_sum_ff <= '0;
         row_sum_ff <= '0;
         tally_ff   <= '0;
         step_ff    <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         col_sum_ff <= col_sum_in;
         row_sum_ff <= row_sum_in;
         tally_ff   <= tally_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            bco_pkg::MSEL_WIDTH:  prod_w_ff <= product;
            bco_pkg::MSEL_TROW:   prod_t_ff <= product;
            bco_pkg::MSEL_HEIGHT: prod_h_ff <= product;
            default: ;
         endcase
      end
      if (cmd.prep_h) begin
         x_ff   <= XW'(h_abs[DW-1:0]) << ERROR_FRAC_BITS;
         den_ff <= prod_w_ff;
         neg_ff <= h_diff[DW];
         rem_ff <= '0;
      end else if (cmd.prep_v) begin
         horiz_ff <= sat_err(x_ff, neg_ff);
         x_ff     <= XW'(v_abs[DW-1:0]) << ERROR_FRAC_BITS;
         den_ff   <= prod_h_ff;
         neg_ff   <= v_diff[DW];
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         x_ff   <= x_step;
         rem_ff <= rem_step;
      end
      if (cmd.load_out) begin
         rsp_found_ff <= found;
         rsp_horiz_ff <= found ? horiz_ff : '0;
         rsp_vert_ff  <= found ? sat_err(x_ff, neg_ff) : '0;
         rsp_count_ff <= tally_ff;
      end
   end

   assign status.frame_end = col_end && row_end;
   assign status.found     = found;
   assign status.div_last  = (step_ff == STEP_W'(1));

   assign rsp_found = rsp_found_ff;
   assign rsp_horiz = rsp_horiz_ff;
   assign rsp_vert  = rsp_vert_ff;
   assign rsp_count = rsp_count_ff;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for blob_centroid_offset
// Streams mask frames through the pixel channel, keeps its own model of the
// column and row position, sums and tally, and checks every per-frame result
// against the predicted found flag, errors and object count. Covers pixel and
// register extremes, not-found rules, size changes inside a frame and random
// frames under sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 200;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int ITEMS_PER_PHASE = 130;
   localparam longint ONE_Q       = longint'(1) << bco_pkg::ERROR_FRAC_BITS_DEF;

   typedef struct packed {
      logic                        found;
      logic [bco_pkg::ERR_W-1:0]   horiz;
      logic [bco_pkg::ERR_W-1:0]   vert;
      logic [bco_pkg::TALLY_W-1:0] count;
   } centroid_type;

   logic                           clock;
   logic                           reset       = 1'b1;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [bco_pkg::PIXEL_W-1:0]    req_tdata   = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [bco_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [bco_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [bco_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [bco_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Register copy and frame position as the block should hold them.
   logic [bco_pkg::SIZE_REG_W-1:0] cfg_width      = bco_pkg::FRAME_WIDTH_RST;
   logic [bco_pkg::SIZE_REG_W-1:0] cfg_height     = bco_pkg::FRAME_HEIGHT_RST;
   logic [bco_pkg::THR_W-1:0]      cfg_threshold  = bco_pkg::THRESHOLD_RST;
   logic [bco_pkg::TALLY_W-1:0]    cfg_min_pixels = bco_pkg::MIN_PIXELS_RST;
   logic [bco_pkg::TROW_W-1:0]     cfg_target_row = bco_pkg::TARGET_ROW_RST;
   logic [9:0]                     pos_col        = '0;
   logic [9:0]                     pos_row        = '0;
   logic [29:0]                    sum_col        = '0;
   logic [29:0]                    sum_row        = '0;
   logic [bco_pkg::TALLY_W-1:0]    dark_count     = '0;

   centroid_type expected_centroids[$];
   int frames_closed  = 0;
   int pixels_sent    = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;

   blob_centroid_offset i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int unsigned clamp_dim(input logic [bco_pkg::SIZE_REG_W-1:0] v,
                                             input int unsigned limit);
      if (v == 0) return 1;
      if (32'(v) > limit) return limit;
      return 32'(v);
   endfunction

   function automatic logic [bco_pkg::ERR_W-1:0] saturate_q(input longint num,
                                                           input longint den);
      longint q;
      q = num / den;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[bco_pkg::ERR_W-1:0];
   endfunction

   // Advances the position by one pixel and queues the frame result at a frame end.
   task automatic track_pixel(input logic [bco_pkg::PIXEL_W-1:0] pix);
      int unsigned w, h;
      longint cnt, hn, vn;
      centroid_type res;
      w = clamp_dim(cfg_width, bco_pkg::MAX_WIDTH_DEF);
      h = clamp_dim(cfg_height, bco_pkg::MAX_HEIGHT_DEF);
      if (pix < cfg_threshold) begin
         sum_col = sum_col + pos_col;
         sum_row = sum_row + pos_row;
         dark_count = dark_count + 1'b1;
      end
      if (pos_col >= w - 1) begin
         pos_col = '0;
         if (pos_row >= h - 1) begin
            pos_row = '0;
            cnt = longint'(dark_count);
            res.found = (dark_count != 0) && (dark_count >= cfg_min_pixels);
            res.horiz = '0;
            res.vert = '0;
            res.count = dark_count;
            if (res.found) begin
               hn = (2 * longint'(sum_col) - longint'(w) * cnt) * ONE_Q;
               vn = 2 * (longint'(sum_row) - longint'(cfg_target_row) * cnt) * ONE_Q;
               res.horiz = saturate_q(hn, longint'(w) * cnt);
               res.vert = saturate_q(vn, longint'(h) * cnt);
            end
            expected_centroids.push_back(res);
            sum_col = '0;
            sum_row = '0;
            dark_count = '0;
            frames_closed++;
         end else begin
            pos_row = pos_row + 1'b1;
         end
      end else begin
         pos_col = pos_col + 1'b1;
      end
   endtask

   always @(posedge clock) begin : check_results
      centroid_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_centroids.size() == 0) begin
            $error("result with no expected item: tuser=%0b tdata=%h", rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_centroids.pop_front();
            if (rsp_tuser !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[bco_pkg::ERR_W-1:0] !== want.horiz) begin
               $error("horiz_error: expected %0d, got %0d",
                      $signed(want.horiz), $signed(rsp_tdata[bco_pkg::ERR_W-1:0]));
               mismatch_count++;
            end
            if (rsp_tdata[2*bco_pkg::ERR_W-1:bco_pkg::ERR_W] !== want.vert) begin
               $error("vert_error: expected %0d, got %0d",
                      $signed(want.vert),
                      $signed(rsp_tdata[2*bco_pkg::ERR_W-1:bco_pkg::ERR_W]));
               mismatch_count++;
            end
            if (rsp_tdata[2*bco_pkg::ERR_W +: bco_pkg::TALLY_W] !== want.count) begin
               $error("object_count: expected %0d, got %0d",
                      want.count, rsp_tdata[2*bco_pkg::ERR_W +: bco_pkg::TALLY_W]);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_pixel(input logic [bco_pkg::PIXEL_W-1:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      track_pixel(pix);
      pixels_sent++;
   endtask

   function automatic logic [bco_pkg::PIXEL_W-1:0] next_pixel();
      case ($urandom_range(3))
         0: return '1;
         1: return bco_pkg::PIXEL_W'($urandom_range(63));
         2: return cfg_threshold - bco_pkg::PIXEL_W'($urandom_range(1));
         default: return bco_pkg::PIXEL_W'($urandom());
      endcase
   endfunction

   // Sends pixels until the position model closes a frame.
   task automatic send_frame();
      int start;
      start = frames_closed;
      while (frames_closed == start) send_pixel(next_pixel());
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_centroids.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bco_pkg::REG_IDX_W-1:0] idx,
                            input logic [bco_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         bco_pkg::REG_FRAME_WIDTH:  cfg_width = value[bco_pkg::SIZE_REG_W-1:0];
         bco_pkg::REG_FRAME_HEIGHT: cfg_height = value[bco_pkg::SIZE_REG_W-1:0];
         bco_pkg::REG_THRESHOLD:    cfg_threshold = value[bco_pkg::THR_W-1:0];
         bco_pkg::REG_MIN_PIXELS:   cfg_min_pixels = value[bco_pkg::TALLY_W-1:0];
         bco_pkg::REG_TARGET_ROW:   cfg_target_row = value[bco_pkg::TROW_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned thr,
                            input int unsigned minp, input int unsigned trow);
      wait_drained();
      write_reg(bco_pkg::REG_FRAME_WIDTH, bco_pkg::CSR_DATA_W'(w));
      write_reg(bco_pkg::REG_FRAME_HEIGHT, bco_pkg::CSR_DATA_W'(h));
      write_reg(bco_pkg::REG_THRESHOLD, bco_pkg::CSR_DATA_W'(thr));
      write_reg(bco_pkg::REG_MIN_PIXELS, bco_pkg::CSR_DATA_W'(minp));
      write_reg(bco_pkg::REG_TARGET_ROW, bco_pkg::CSR_DATA_W'(trow));
   endtask

   task automatic test_pixel_extremes();
      logic [bco_pkg::PIXEL_W-1:0] pattern[12] = '{8'h00, 8'hff, 8'h7f, 8'h80, 8'h01, 8'hfe,
                                                   8'h40, 8'hc8, 8'h00, 8'h00, 8'hff, 8'h80};
      set_frame(4, 3, 128, 1, 0);
      foreach (pattern[i]) send_pixel(pattern[i]);
   endtask

   task automatic test_found_rules();
      // Empty frame stays not found even with a minimum of zero.
      set_frame(2, 1, 0, 0, 0);
      send_pixel(8'h00);
      send_pixel(8'h00);
      // Tally below the minimum still reports its count.
      set_frame(3, 1, 255, 3, 0);
      send_pixel(8'hfe);
      send_pixel(8'hff);
      send_pixel(8'h00);
      set_frame(2, 1, 255, 1048576, 0);
      send_pixel(8'h00);
      send_pixel(8'h00);
      // A target row far below a one-row frame drives the vertical error to its limit.
      set_frame(2, 1, 128, 2, 1023);
      send_pixel(8'h00);
      send_pixel(8'h00);
   endtask

   task automatic test_resize_mid_frame();
      set_frame(8, 6, 128, 0, 2);
      repeat (13) send_pixel(next_pixel());
      wait_drained();
      write_reg(bco_pkg::REG_FRAME_WIDTH, bco_pkg::CSR_DATA_W'(3));
      send_frame();
      wait_drained();
      write_reg(bco_pkg::REG_FRAME_WIDTH, bco_pkg::CSR_DATA_W'(8));
      repeat (26) send_pixel(next_pixel());
      wait_drained();
      write_reg(bco_pkg::REG_FRAME_WIDTH, bco_pkg::CSR_DATA_W'(2));
      write_reg(bco_pkg::REG_FRAME_HEIGHT, bco_pkg::CSR_DATA_W'(2));
      send_frame();
   endtask

   task automatic test_frame_size_limits();
      // Zero sizes act as one.
      set_frame(0, 4, 128, 0, 0);
      send_frame();
      set_frame(6, 0, 128, 1, 1023);
      send_frame();
      // Oversized sizes act as the maximum, then a smaller size closes the partial row.
      set_frame(2047, 2047, 200, 1, 512);
      repeat (40) send_pixel(next_pixel());
      wait_drained();
      write_reg(bco_pkg::REG_FRAME_WIDTH, bco_pkg::CSR_DATA_W'(6));
      write_reg(bco_pkg::REG_FRAME_HEIGHT, bco_pkg::CSR_DATA_W'(1));
      send_frame();
      // Oversized height with one-pixel rows, closed by a smaller height.
      set_frame(1, 2047, 50, 0, 512);
      repeat (30) send_pixel(next_pixel());
      wait_drained();
      write_reg(bco_pkg::REG_FRAME_HEIGHT, bco_pkg::CSR_DATA_W'(3));
      send_frame();
   endtask

   task automatic test_random_frames();
      int idle_by_phase[4]  = '{0, 65, 0, 37};
      int stall_by_phase[4] = '{0, 0, 65, 37};
      int start;
      int unsigned fw, fh, thr, minp, trow;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_by_phase[ph];
         stall_pct = stall_by_phase[ph];
         start = pixels_sent;
         while (pixels_sent - start < ITEMS_PER_PHASE) begin
            fw = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
            fh = $urandom_range(6);
            thr = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 255 : 0) : $urandom_range(255);
            case ($urandom_range(7))
               0: minp = 0;
               1, 2: minp = $urandom_range(4, 1);
               7: minp = $urandom_range(1) ? 1048576 : 2097151;
               default: minp = $urandom_range(fw * (fh + 1));
            endcase
            trow = ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(7);
            set_frame(fw, fh, thr, minp, trow);
            repeat ($urandom_range(3, 1)) begin
               if ($urandom_range(4) == 0) wait_drained();
               send_frame();
            end
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_pixel_extremes();
      test_found_rules();
      test_resize_mid_frame();
      test_frame_size_limits();
      test_random_frames();
      wait_drained();
      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bco_pkg.sv
rtl/bco_csr.sv
rtl/bco_ctrl.sv
rtl/bco_dp.sv
rtl/blob_centroid_offset.sv
test/testbench.sv
